// File: design/tkul_pkg.sv
// Shared types, constants and helpers for the terminal key and utf-8 lexer.
// No dependencies; imported by tkul_core, terminal_key_utf8_lexer and the bench.
package tkul_pkg;

  // default width of the csi argument and utf-8 accumulators
  localparam int ArgWidthDef = 32;

  // result field widths
  localparam int KindW = 4;
  localparam int CpW   = 21;
  localparam int RptW  = 16;

  // byte codes with a meaning of their own
  localparam logic [7:0] ByteEot   = 8'h03;
  localparam logic [7:0] ByteLf    = 8'h0A;
  localparam logic [7:0] ByteCr    = 8'h0D;
  localparam logic [7:0] ByteEsc   = 8'h1B;
  localparam logic [7:0] ByteDel   = 8'h7F;
  localparam logic [7:0] ByteSpace = 8'h20;
  localparam logic [7:0] ByteZero  = 8'h30;
  localparam logic [7:0] ByteNine  = 8'h39;
  localparam logic [7:0] ByteSemi  = 8'h3B;
  localparam logic [7:0] ByteAt    = 8'h40;
  localparam logic [7:0] ByteO     = 8'h4F;
  localparam logic [7:0] ByteR     = 8'h52;
  localparam logic [7:0] ByteLbrk  = 8'h5B;
  localparam logic [7:0] ByteTilde = 8'h7E;
  localparam logic [7:0] ByteUp    = 8'h41;
  localparam logic [7:0] ByteDown  = 8'h42;
  localparam logic [7:0] ByteRight = 8'h43;
  localparam logic [7:0] ByteLeft  = 8'h44;
  localparam logic [7:0] ByteEnd   = 8'h46;
  localparam logic [7:0] ByteHome  = 8'h48;

  // lead byte masks and patterns
  localparam logic [7:0] Lead2Mask = 8'hE0;
  localparam logic [7:0] Lead2Pat  = 8'hC0;
  localparam logic [7:0] Lead3Mask = 8'hF0;
  localparam logic [7:0] Lead3Pat  = 8'hE0;
  localparam logic [7:0] Lead4Mask = 8'hF8;
  localparam logic [7:0] Lead4Pat  = 8'hF0;
  localparam logic [7:0] ContMask  = 8'hC0;
  localparam logic [7:0] ContPat   = 8'h80;

  // escape argument values for the tilde keys
  localparam int TildeHome = 1;
  localparam int TildeDel  = 3;
  localparam int TildeEnd  = 4;

  // lexer mode
  typedef enum logic [4:0] {
    MODE_PLAIN = 5'b00001,
    MODE_ESC   = 5'b00010,
    MODE_CSI   = 5'b00100,
    MODE_SS3   = 5'b01000,
    MODE_SKIP  = 5'b10000
  } mode_t;

  // token kinds
  typedef enum logic [KindW-1:0] {
    TK_CODE   = 4'd0,
    TK_REPORT = 4'd1,
    TK_UP     = 4'd2,
    TK_DOWN   = 4'd3,
    TK_LEFT   = 4'd4,
    TK_RIGHT  = 4'd5,
    TK_ENTER  = 4'd6,
    TK_BKSP   = 4'd7,
    TK_DELETE = 4'd8,
    TK_HOME   = 4'd9,
    TK_END    = 4'd10,
    TK_EOT    = 4'd11
  } kind_t;

  // one result item
  typedef struct packed {
    kind_t           kind;
    logic [CpW-1:0]  char_val;
    logic [RptW-1:0] report_row;
    logic [RptW-1:0] report_col;
  } token_t;

  // arrow, home and end finals shared by ss3 and csi; TK_CODE when none
  function automatic kind_t cursor_final(input logic [7:0] b);
    kind_t k;
    k = TK_CODE;
    case (b)
      ByteUp:    k = TK_UP;
      ByteDown:  k = TK_DOWN;
      ByteRight: k = TK_RIGHT;
      ByteLeft:  k = TK_LEFT;
      ByteHome:  k = TK_HOME;
      ByteEnd:   k = TK_END;
      default:   k = TK_CODE;
    endcase
    return k;
  endfunction

endpackage

// File: design/tkul_core.sv
// Lexer state registers and the one-byte update logic.
// Depends on tkul_pkg for mode and token types and byte codes.
module tkul_core import tkul_pkg::*; #(
  parameter int ARG_WIDTH = ArgWidthDef
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       step,      // commit the update for in_byte this cycle
  input  logic [7:0] in_byte,
  output logic       emit,      // in_byte produces a token
  output token_t     token
);

  mode_t                mode, mode_next;
  logic [1:0]           pend, pend_next;
  logic [1:0]           idx, idx_next;
  logic [ARG_WIDTH-1:0] arg0, arg0_next;
  logic [ARG_WIDTH-1:0] arg1, arg1_next;

  logic                 do_clear;
  logic [ARG_WIDTH-1:0] acc_sel, acc_mul, cont_val;
  logic [1:0]           pend_dec;
  kind_t                fin;

  // shared helpers: csi digit accumulate and utf-8 continuation shift
  assign acc_sel  = idx[0] ? arg1 : arg0;
  assign acc_mul  = (acc_sel << 3) + (acc_sel << 1) + ARG_WIDTH'(in_byte[3:0]);
  assign cont_val = (arg0 << 6) | ARG_WIDTH'(in_byte[5:0]);
  assign pend_dec = pend - 2'd1;
  assign fin      = cursor_final(in_byte);

  // next state and token for one byte
  always_comb begin
    mode_next = mode;
    pend_next = pend;
    idx_next  = idx;
    arg0_next = arg0;
    arg1_next = arg1;
    do_clear  = 1'b0;
    emit      = 1'b0;
    token     = '0;

    if (in_byte == ByteEot) begin
      emit       = 1'b1;
      token.kind = TK_EOT;
    end else if (in_byte == ByteLf || in_byte == ByteCr) begin
      emit       = 1'b1;
      token.kind = TK_ENTER;
    end else if (in_byte == ByteDel) begin
      emit       = 1'b1;
      token.kind = TK_BKSP;
    end else if (in_byte == ByteEsc) begin
      mode_next = MODE_ESC;
    end else if (in_byte < ByteSpace) begin
      do_clear = 1'b1;
    end else if ((in_byte & Lead2Mask) == Lead2Pat) begin
      mode_next = MODE_PLAIN;
      pend_next = 2'd1;
      arg0_next = ARG_WIDTH'(in_byte[4:0]);
    end else if ((in_byte & Lead3Mask) == Lead3Pat) begin
      mode_next = MODE_PLAIN;
      pend_next = 2'd2;
      arg0_next = ARG_WIDTH'(in_byte[3:0]);
    end else if ((in_byte & Lead4Mask) == Lead4Pat) begin
      mode_next = MODE_PLAIN;
      pend_next = 2'd3;
      arg0_next = ARG_WIDTH'(in_byte[2:0]);
    end else if ((in_byte & ContMask) == ContPat) begin
      if (pend == 2'd0) begin
        do_clear = 1'b1;
      end else begin
        arg0_next = cont_val;
        pend_next = pend_dec;
        if (pend_dec == 2'd0) begin
          emit           = 1'b1;
          token.kind     = TK_CODE;
          token.char_val = cont_val[CpW-1:0];
        end
      end
    end else if (in_byte[7]) begin
      // invalid lead bytes leave everything alone
      mode_next = mode;
    end else begin
      pend_next = 2'd0;
      unique case (mode)
        MODE_PLAIN: begin
          emit           = 1'b1;
          token.kind     = TK_CODE;
          token.char_val = CpW'(in_byte);
        end
        MODE_ESC: begin
          if (in_byte == ByteLbrk) begin
            mode_next = MODE_CSI;
            idx_next  = 2'd0;
            arg0_next = '0;
            arg1_next = '0;
          end else if (in_byte == ByteO) begin
            mode_next = MODE_SS3;
          end else begin
            do_clear = 1'b1;
          end
        end
        MODE_SS3: begin
          if (fin != TK_CODE) begin
            emit       = 1'b1;
            token.kind = fin;
          end else begin
            do_clear = 1'b1;
          end
        end
        MODE_CSI: begin
          if (in_byte == ByteSpace) begin
            mode_next = MODE_CSI;
          end else if (in_byte >= ByteZero && in_byte <= ByteNine) begin
            if (idx[0]) arg1_next = acc_mul;
            else        arg0_next = acc_mul;
          end else if (in_byte == ByteSemi) begin
            idx_next = idx + 2'd1;
            if (idx + 2'd1 >= 2'd2) mode_next = MODE_SKIP;
          end else if (in_byte >= ByteAt && in_byte <= ByteTilde) begin
            if (fin != TK_CODE) begin
              emit       = 1'b1;
              token.kind = fin;
            end else if (in_byte == ByteR) begin
              emit             = 1'b1;
              token.kind       = TK_REPORT;
              token.report_row = arg0[RptW-1:0];
              token.report_col = arg1[RptW-1:0];
            end else if (in_byte == ByteTilde && arg0 == ARG_WIDTH'(TildeHome)) begin
              emit       = 1'b1;
              token.kind = TK_HOME;
            end else if (in_byte == ByteTilde && arg0 == ARG_WIDTH'(TildeDel)) begin
              emit       = 1'b1;
              token.kind = TK_DELETE;
            end else if (in_byte == ByteTilde && arg0 == ARG_WIDTH'(TildeEnd)) begin
              emit       = 1'b1;
              token.kind = TK_END;
            end else begin
              do_clear = 1'b1;
            end
          end else begin
            mode_next = MODE_SKIP;
          end
        end
        MODE_SKIP: begin
          if (in_byte >= ByteAt && in_byte <= ByteTilde) do_clear = 1'b1;
        end
        default: begin
          do_clear = 1'b1;
        end
      endcase
    end

    // every token and every abort returns to the reset state
    if (do_clear || emit) begin
      mode_next = MODE_PLAIN;
      pend_next = 2'd0;
      idx_next  = 2'd0;
      arg0_next = '0;
      arg1_next = '0;
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_PLAIN;
      pend <= 2'd0;
      idx  <= 2'd0;
      arg0 <= '0;
      arg1 <= '0;
    end else if (step) begin
      mode <= mode_next;
      pend <= pend_next;
      idx  <= idx_next;
      arg0 <= arg0_next;
      arg1 <= arg1_next;
    end
  end

endmodule

// File: design/terminal_key_utf8_lexer.sv
// Top level of the terminal key and utf-8 lexer: byte input register,
// token output register and stream handshakes. Uses tkul_pkg and tkul_core.
//
// Takes one terminal byte per transfer and returns zero or one key token per
// byte. A byte is accepted every cycle when the output side keeps up; a byte
// is held in the input register, is decoded against the lexer state in one
// pass, and its token is registered in the output register when the byte
// moves on. The input register and the output register stall together only
// while a token waits untaken. Bytes that close nothing (escape prefixes,
// digits, utf-8 lead bytes) give no output transfer.
module terminal_key_utf8_lexer import tkul_pkg::*; #(
  parameter int ARG_WIDTH = ArgWidthDef
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // in_byte[7:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // char_val[20:0], report_row[36:21],
                                 // report_col[52:37], zero fill
  output logic [3:0]  m_tuser    // token_kind[3:0]
);

  logic       in_valid;
  logic [7:0] in_byte;
  logic       adv;
  logic       emit;
  token_t     token;
  token_t     out_tok;

  // byte moves on when the output register is free or being emptied
  assign adv      = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || adv;

  tkul_core #(
    .ARG_WIDTH(ARG_WIDTH)
  ) u_core (
    .clk     (clk),
    .rst     (rst),
    .step    (adv),
    .in_byte (in_byte),
    .emit    (emit),
    .token   (token)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (adv) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv && emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && emit) begin
      out_tok <= token;
    end
  end

  // pack the result fields
  assign m_tuser = out_tok.kind;
  assign m_tdata = {3'b000, out_tok.report_col, out_tok.report_row, out_tok.char_val};

endmodule

// File: bench/terminal_key_utf8_lexer_test.sv
// Self-checking bench for terminal_key_utf8_lexer: feeds terminal byte
// streams and checks every key token against a built-in lexer model.
// Depends on tkul_pkg and the terminal_key_utf8_lexer design files.
module terminal_key_utf8_lexer_test;
  import tkul_pkg::*;

  localparam int ArgW       = ArgWidthDef;
  localparam int PhaseBytes = 330;
  localparam int CycleLimit = 600000;
  localparam int TailCycles = 20;

  logic        clk;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata  = 8'h00;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_tdata;
  logic [3:0]  m_tuser;

  terminal_key_utf8_lexer dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // bytes waiting to be sent and tokens waiting to arrive
  logic [7:0] pending_bytes[$];
  token_t     expected_tokens[$];

  int bytes_queued   = 0;
  int bytes_counted  = 0;
  int bytes_accepted = 0;
  int send_idle_pct  = 0;
  int stall_pct      = 0;
  int errors         = 0;
  int cycles         = 0;

  // lexer state as the bench tracks it
  mode_t           lex_mode;
  logic [1:0]      utf_left;
  logic [1:0]      arg_idx;
  logic [ArgW-1:0] arg_val[2];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    errors++;
    if (errors <= 10) $display("%s", msg);
  endtask

  task automatic clear_lexer();
    lex_mode   = MODE_PLAIN;
    utf_left   = 2'd0;
    arg_idx    = 2'd0;
    arg_val[0] = '0;
    arg_val[1] = '0;
  endtask

  // arrow, home and end final bytes; TK_CODE for anything else
  function automatic kind_t key_of_final(input logic [7:0] b);
    case (b)
      ByteUp:    return TK_UP;
      ByteDown:  return TK_DOWN;
      ByteRight: return TK_RIGHT;
      ByteLeft:  return TK_LEFT;
      ByteHome:  return TK_HOME;
      ByteEnd:   return TK_END;
      default:   return TK_CODE;
    endcase
  endfunction

  // advance the lexer by one byte and queue the token it yields, if any
  task automatic lex_byte(input logic [7:0] b);
    token_t tok;
    kind_t  k;
    logic   hit;
    tok = '0;
    hit = 1'b0;
    if (b == ByteEot) begin
      hit = 1'b1;
      tok.kind = TK_EOT;
    end else if (b == ByteLf || b == ByteCr) begin
      hit = 1'b1;
      tok.kind = TK_ENTER;
    end else if (b == ByteDel) begin
      hit = 1'b1;
      tok.kind = TK_BKSP;
    end else if (b == ByteEsc) begin
      lex_mode = MODE_ESC;
    end else if (b < ByteSpace) begin
      clear_lexer();
    end else if ((b & Lead2Mask) == Lead2Pat) begin
      lex_mode   = MODE_PLAIN;
      utf_left   = 2'd1;
      arg_val[0] = ArgW'(b[4:0]);
    end else if ((b & Lead3Mask) == Lead3Pat) begin
      lex_mode   = MODE_PLAIN;
      utf_left   = 2'd2;
      arg_val[0] = ArgW'(b[3:0]);
    end else if ((b & Lead4Mask) == Lead4Pat) begin
      lex_mode   = MODE_PLAIN;
      utf_left   = 2'd3;
      arg_val[0] = ArgW'(b[2:0]);
    end else if ((b & ContMask) == ContPat) begin
      // continuation byte: stray ones reset, the last one closes a code point
      if (utf_left == 2'd0) begin
        clear_lexer();
      end else begin
        arg_val[0] = {arg_val[0][ArgW-7:0], b[5:0]};
        utf_left   = utf_left - 2'd1;
        if (utf_left == 2'd0) begin
          hit = 1'b1;
          tok.kind = TK_CODE;
          tok.char_val = arg_val[0][CpW-1:0];
        end
      end
    end else if (b < 8'h80) begin
      // ascii byte: drops any unfinished utf-8 sequence
      utf_left = 2'd0;
      case (lex_mode)
        MODE_PLAIN: begin
          hit = 1'b1;
          tok.kind = TK_CODE;
          tok.char_val = CpW'(b);
        end
        MODE_ESC: begin
          if (b == ByteLbrk) begin
            lex_mode   = MODE_CSI;
            arg_idx    = 2'd0;
            arg_val[0] = '0;
            arg_val[1] = '0;
          end else if (b == ByteO) begin
            lex_mode = MODE_SS3;
          end else begin
            clear_lexer();
          end
        end
        MODE_SS3: begin
          k = key_of_final(b);
          if (k != TK_CODE) begin
            hit = 1'b1;
            tok.kind = k;
          end else begin
            clear_lexer();
          end
        end
        MODE_CSI: begin
          if (b == ByteSpace) begin
            // ignored inside csi
          end else if (b >= ByteZero && b <= ByteNine) begin
            arg_val[arg_idx[0]] = arg_val[arg_idx[0]] * 10 + ArgW'(b - ByteZero);
          end else if (b == ByteSemi) begin
            arg_idx = arg_idx + 2'd1;
            if (arg_idx >= 2'd2) lex_mode = MODE_SKIP;
          end else if (b >= ByteAt && b <= ByteTilde) begin
            k = key_of_final(b);
            hit = 1'b1;
            if (k != TK_CODE) begin
              tok.kind = k;
            end else if (b == ByteR) begin
              tok.kind = TK_REPORT;
              tok.report_row = arg_val[0][RptW-1:0];
              tok.report_col = arg_val[1][RptW-1:0];
            end else if (b == ByteTilde && arg_val[0] == ArgW'(TildeHome)) begin
              tok.kind = TK_HOME;
            end else if (b == ByteTilde && arg_val[0] == ArgW'(TildeDel)) begin
              tok.kind = TK_DELETE;
            end else if (b == ByteTilde && arg_val[0] == ArgW'(TildeEnd)) begin
              tok.kind = TK_END;
            end else begin
              hit = 1'b0;
              clear_lexer();
            end
          end else begin
            // intermediate byte: skip the rest of the sequence
            lex_mode = MODE_SKIP;
          end
        end
        MODE_SKIP: begin
          if (b >= ByteAt && b <= ByteTilde) clear_lexer();
        end
        default: clear_lexer();
      endcase
    end
    if (hit) begin
      clear_lexer();
      expected_tokens.push_back(tok);
    end
  endtask

  // stimulus building blocks
  task automatic add_byte(input logic [7:0] b);
    pending_bytes.push_back(b);
    bytes_queued++;
    if (b < 8'hF8) bytes_counted++;
  endtask

  task automatic add_digits(input int n);
    for (int i = 0; i < n; i++) add_byte(ByteZero + 8'($urandom_range(0, 9)));
  endtask

  task automatic add_cursor_final();
    case ($urandom_range(0, 5))
      0:       add_byte(ByteUp);
      1:       add_byte(ByteDown);
      2:       add_byte(ByteRight);
      3:       add_byte(ByteLeft);
      4:       add_byte(ByteHome);
      default: add_byte(ByteEnd);
    endcase
  endtask

  task automatic add_utf8(input int len, input int conts);
    case (len)
      2:       add_byte({3'b110, 5'($urandom)});
      3:       add_byte({4'b1110, 4'($urandom)});
      default: add_byte({5'b11110, 3'($urandom)});
    endcase
    for (int i = 0; i < conts; i++) add_byte({2'b10, 6'($urandom)});
  endtask

  // one random chunk: mostly well-formed sequences, some noise
  task automatic add_random_chunk();
    int pick;
    int nargs;
    int fin;
    int len;
    pick = $urandom_range(0, 99);
    if (pick < 14) begin
      add_byte(8'($urandom_range(8'h20, 8'h7E)));
    end else if (pick < 28) begin
      len = $urandom_range(2, 4);
      add_utf8(len, len - 1);
    end else if (pick < 38) begin
      add_byte(ByteEsc);
      add_byte(ByteO);
      if ($urandom_range(0, 4) == 0) add_byte(8'($urandom_range(8'h20, 8'h7E)));
      else add_cursor_final();
    end else if (pick < 70) begin
      // csi with random arguments and final byte
      add_byte(ByteEsc);
      add_byte(ByteLbrk);
      fin   = $urandom_range(0, 3);
      nargs = $urandom_range(0, 3);
      for (int i = 0; i < nargs; i++) begin
        if (i > 0) add_byte(ByteSemi);
        if ($urandom_range(0, 9) == 0) add_byte(ByteSpace);
        if (fin == 1 && i == 0 && $urandom_range(0, 3) != 0) begin
          case ($urandom_range(0, 2))
            0:       add_byte(ByteZero + 8'(TildeHome));
            1:       add_byte(ByteZero + 8'(TildeDel));
            default: add_byte(ByteZero + 8'(TildeEnd));
          endcase
        end else if ($urandom_range(0, 9) == 0) begin
          add_digits($urandom_range(10, 14));
        end else begin
          add_digits($urandom_range(0, 3));
        end
      end
      if ($urandom_range(0, 19) == 0) begin
        if ($urandom_range(0, 1) == 0) add_byte(8'($urandom_range(8'h21, 8'h2F)));
        else add_byte(8'($urandom_range(8'h3C, 8'h3F)));
      end
      case (fin)
        0:       add_byte(ByteR);
        1:       add_byte(ByteTilde);
        2:       add_cursor_final();
        default: add_byte(8'($urandom_range(8'h40, 8'h7E)));
      endcase
    end else if (pick < 78) begin
      add_byte(8'($urandom_range(8'h00, 8'h1F)));
    end else if (pick < 90) begin
      // broken utf-8: cut short, escape in the middle, or stray continuation
      len = $urandom_range(2, 4);
      case ($urandom_range(0, 2))
        0: begin
          add_utf8(len, $urandom_range(0, len - 2));
          add_byte(8'($urandom_range(8'h20, 8'h7E)));
        end
        1: begin
          add_utf8(len, 0);
          add_byte(ByteEsc);
          for (int i = 1; i < len; i++) add_byte({2'b10, 6'($urandom)});
        end
        default: add_byte(8'($urandom_range(8'h80, 8'hBF)));
      endcase
    end else begin
      add_byte(8'($urandom_range(0, 255)));
    end
  endtask

  // byte driver and prediction at each accepted transfer
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      clear_lexer();
    end else begin
      if (s_tvalid && s_tready) begin
        lex_byte(s_tdata);
        bytes_accepted++;
      end
      if (!s_tvalid || s_tready) begin
        if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          s_tdata  <= pending_bytes.pop_front();
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // token monitor and output back-pressure
  always @(posedge clk) begin
    token_t got;
    token_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.kind       = kind_t'(m_tuser);
        got.char_val   = m_tdata[20:0];
        got.report_row = m_tdata[36:21];
        got.report_col = m_tdata[52:37];
        if (expected_tokens.size() == 0) begin
          report_mismatch($sformatf("unexpected token: kind %0d cp %h row %0d col %0d",
                                    got.kind, got.char_val, got.report_row,
                                    got.report_col));
        end else begin
          want = expected_tokens.pop_front();
          if (got.kind !== want.kind || got.char_val !== want.char_val ||
              got.report_row !== want.report_row || got.report_col !== want.report_col)
            report_mismatch($sformatf({"token mismatch: expected kind %0d cp %h row %0d ",
                                       "col %0d, got kind %0d cp %h row %0d col %0d"},
                                      want.kind, want.char_val, want.report_row,
                                      want.report_col, got.kind, got.char_val,
                                      got.report_row, got.report_col));
        end
      end
      m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // phases: free flow, idle sender, stalled receiver, both
  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 82; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 82; end
        default: begin send_idle_pct = 31; stall_pct = 31; end
      endcase
      if (ph == 0) begin
        // control keys, byte extremes, ss3 home, cursor report with a space,
        // 4-byte code point, stray continuation, tilde delete
        add_byte(ByteEot); add_byte(ByteLf); add_byte(ByteCr); add_byte(ByteDel);
        add_byte(8'h00); add_byte(8'hFF); add_byte(ByteUp);
        add_byte(ByteEsc); add_byte(ByteO); add_byte(ByteHome);
        add_byte(ByteEsc); add_byte(ByteLbrk); add_byte(ByteZero + 8'd9);
        add_byte(ByteSpace); add_byte(ByteSemi); add_byte(ByteZero + 8'd7);
        add_byte(ByteR);
        add_byte(8'hF0); add_byte(8'h9F); add_byte(8'h98); add_byte(8'h80);
        add_byte(8'h80);
        add_byte(ByteEsc); add_byte(ByteLbrk); add_byte(ByteZero + 8'(TildeDel));
        add_byte(ByteTilde);
      end
      while (bytes_counted < (ph + 1) * PhaseBytes) add_random_chunk();
      // hold the sender until every token of this phase is back
      while (bytes_accepted != bytes_queued || expected_tokens.size() != 0)
        @(posedge clk);
    end
    repeat (TailCycles) @(posedge clk);
    if (expected_tokens.size() != 0)
      report_mismatch($sformatf("%0d tokens never arrived", expected_tokens.size()));
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
